// File: hdl/ssp_pkg.sv
`default_nettype none

package ssp_pkg;

    // Block configuration
    localparam int CHANNEL_COUNT     = 3;
    localparam int VALVE_CHANNEL     = 2;
    localparam int VALVE_RESET_ANGLE = 0;
    localparam int DEADBAND          = 10;

    // Full travel in hundredths of a degree
    localparam int SPAN   = 18000;
    localparam int SPAN_W = 15;

    // Field widths
    localparam int ACT_W    = 2;
    localparam int CH_W     = 3;
    localparam int ANGLE_W  = 15;
    localparam int AIO_W    = 16;
    localparam int PULSE_W  = 16;
    localparam int PERIOD_W = 20;
    localparam int BITS_W   = 5;
    localparam int DUTY_W   = 16;

    localparam int CH_IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_ANGLE    = 3'd0,
        CFG_MAX_ANGLE    = 3'd1,
        CFG_CENTER_ANGLE = 3'd2,
        CFG_MIN_PULSE    = 3'd3,
        CFG_MAX_PULSE    = 3'd4,
        CFG_PERIOD       = 3'd5,
        CFG_DUTY_BITS    = 3'd6
    } cfg_idx_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_SET  = 2'd0,
        ACT_MOVE = 2'd1,
        ACT_GET  = 2'd2
    } act_t;

    // Register reset values
    localparam logic [ANGLE_W-1:0]  MIN_ANGLE_RST    = 15'd0;
    localparam logic [ANGLE_W-1:0]  MAX_ANGLE_RST    = 15'd18000;
    localparam logic [ANGLE_W-1:0]  CENTER_ANGLE_RST = 15'd9000;
    localparam logic [PULSE_W-1:0]  MIN_PULSE_RST    = 16'd500;
    localparam logic [PULSE_W-1:0]  MAX_PULSE_RST    = 16'd2500;
    localparam logic [PERIOD_W-1:0] PERIOD_RST       = 20'd20000;
    localparam logic [BITS_W-1:0]   DUTY_BITS_RST    = 5'd16;

    // Datapath widths for the duty computation
    localparam int X_W    = ANGLE_W + 3;           // move target before clamping
    localparam int BASE_W = PULSE_W + SPAN_W;      // min_pulse * span
    localparam int PROD_W = 33;                    // signed pulse numerator
    localparam int NPOS_W = PROD_W - 1;            // positive numerator
    localparam int N_W    = NPOS_W + DUTY_W;       // numerator times full scale
    localparam int D_W    = PERIOD_W + SPAN_W;     // span * period
    localparam int DSH_W  = D_W + DUTY_W - 1;      // divisor aligned to top quotient bit
    localparam int CNT_W  = 4;

    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(ANGLE_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DUTY_W - 1);

endpackage

`default_nettype wire

// File: hdl/ssp_in_if.sv
`default_nettype none

interface ssp_in_if;
    import ssp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [ACT_W-1:0]        action;
    logic [CH_W-1:0]         channel;
    logic signed [AIO_W-1:0] target_angle;
    logic signed [AIO_W-1:0] current_angle;
    logic [ANGLE_W-1:0]      step_limit;

    modport source (
        output valid, action, channel, target_angle, current_angle, step_limit,
        input  ready
    );

    modport sink (
        input  valid, action, channel, target_angle, current_angle, step_limit,
        output ready
    );

endinterface

`default_nettype wire

// File: hdl/ssp_out_if.sv
`default_nettype none

interface ssp_out_if;
    import ssp_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [AIO_W-1:0] angle_out;
    logic [DUTY_W-1:0]       duty;
    logic                    duty_written;
    logic [CH_W-1:0]         channel_out;

    modport source (
        output valid, angle_out, duty, duty_written, channel_out,
        input  ready
    );

    modport sink (
        input  valid, angle_out, duty, duty_written, channel_out,
        output ready
    );

endinterface

`default_nettype wire

// File: hdl/servo_slew_pwm_duty.sv
`default_nettype none

// Servo angle controller with slew limiting and PWM duty output. One command
// beat is taken at a time and always yields one result beat. A get, a bad
// channel or a move inside the deadband passes the move, clamp and done
// states only. A set or move that updates the channel runs a bit-serial
// shift-add multiplier (one angle bit each step) for the pulse width and a
// restoring divider (one duty bit each step) for the duty; zero and full-scale
// duties skip the divider. The result sits in an output register, so the next
// command is taken while it waits, but not before this result is there. The user
// must write configuration through cfg_write/cfg_index/cfg_data while no command
// is in flight; the block itself does not enforce this.
module servo_slew_pwm_duty (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [ssp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [ssp_pkg::CFG_DATA_W-1:0]  cfg_data,
    ssp_in_if.sink                               cmd,
    ssp_out_if.source                            res
);
    import ssp_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MOVE  = 8'b0000_0010,
        ST_CLAMP = 8'b0000_0100,
        ST_MUL   = 8'b0000_1000,
        ST_NUM   = 8'b0001_0000,
        ST_SAT   = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    // Control and configuration state
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                res_valid_reg, res_valid_next;
    logic [ANGLE_W-1:0]  min_angle_reg, min_angle_next;
    logic [ANGLE_W-1:0]  max_angle_reg, max_angle_next;
    logic [ANGLE_W-1:0]  center_reg, center_next;
    logic [PULSE_W-1:0]  min_pulse_reg, min_pulse_next;
    logic [PULSE_W-1:0]  max_pulse_reg, max_pulse_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [BITS_W-1:0]   bits_reg, bits_next;
    logic [ANGLE_W-1:0]  stored_reg [CHANNEL_COUNT];
    logic [ANGLE_W-1:0]  stored_next [CHANNEL_COUNT];

    // Datapath
    act_t                    act_reg, act_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic signed [AIO_W-1:0] tgt_reg, tgt_next;
    logic signed [AIO_W-1:0] cur_reg, cur_next;
    logic [ANGLE_W-1:0]      step_reg, step_next;
    logic signed [X_W-1:0]   x_reg, x_next;
    logic                    wr_reg, wr_next;
    logic [AIO_W-1:0]        pass_reg, pass_next;
    logic [AIO_W-1:0]        angle_reg, angle_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] mcand_reg, mcand_next;
    logic [ANGLE_W-1:0]      mpl_reg, mpl_next;
    logic [BASE_W-1:0]       base_reg, base_next;
    logic [D_W-1:0]          d_reg, d_next;
    logic [N_W-1:0]          rem_reg, rem_next;
    logic [DSH_W-1:0]        dsh_reg, dsh_next;
    logic [DUTY_W-1:0]       q_reg, q_next;
    logic [DUTY_W-1:0]       duty_reg, duty_next;
    logic [AIO_W-1:0]        res_angle_reg, res_angle_next;
    logic [DUTY_W-1:0]       res_duty_reg, res_duty_next;
    logic                    res_wr_reg, res_wr_next;
    logic [CH_W-1:0]         res_ch_reg, res_ch_next;

    // Combinational helpers
    logic                    ch_valid;
    logic [CH_IDX_W-1:0]     ch_idx;
    logic signed [X_W-1:0]   tgt_x, cur_x, step_x, move_x, min_x, max_x;
    logic signed [AIO_W:0]   diff;
    logic [AIO_W:0]          mag;
    logic                    near, out_band;
    logic [ANGLE_W-1:0]      clamp_a;
    logic [AIO_W-1:0]        get_angle;
    logic signed [PULSE_W:0] pulse_diff;
    logic [PERIOD_W-1:0]     period_eff;
    logic [BITS_W-1:0]       bits_eff;
    logic [DUTY_W-1:0]       full;
    logic signed [PROD_W-1:0] acc_add, num;
    logic                    num_pos;
    logic [N_W-1:0]          nfull;
    logic                    sat;
    logic                    ge;
    logic [DUTY_W-1:0]       q_step, q_sat;

    assign cmd.ready        = (state_reg == ST_IDLE);
    assign res.valid        = res_valid_reg;
    assign res.angle_out    = res_angle_reg;
    assign res.duty         = res_duty_reg;
    assign res.duty_written = res_wr_reg;
    assign res.channel_out  = res_ch_reg;

    // Channel decode and stored angle read
    assign ch_valid  = ({1'b0, ch_reg} < (CH_W + 1)'(CHANNEL_COUNT));
    assign ch_idx    = ch_reg[CH_IDX_W-1:0];
    assign get_angle = ch_valid ? {1'b0, stored_reg[ch_idx]} : {1'b0, center_reg};

    // Slew step toward target
    assign tgt_x    = {{(X_W - AIO_W){tgt_reg[AIO_W-1]}}, tgt_reg};
    assign cur_x    = {{(X_W - AIO_W){cur_reg[AIO_W-1]}}, cur_reg};
    assign step_x   = {{(X_W - ANGLE_W){1'b0}}, step_reg};
    assign diff     = {tgt_reg[AIO_W-1], tgt_reg} - {cur_reg[AIO_W-1], cur_reg};
    assign mag      = diff[AIO_W] ? ((AIO_W + 1)'(0) - diff) : diff;
    assign near     = (mag <= {{(AIO_W + 1 - ANGLE_W){1'b0}}, step_reg});
    assign out_band = (mag >= (AIO_W + 1)'(DEADBAND));
    assign move_x   = near ? tgt_x : (diff[AIO_W] ? (cur_x - step_x) : (cur_x + step_x));

    // Clamp to limits, lower limit first
    assign min_x   = {{(X_W - ANGLE_W){1'b0}}, min_angle_reg};
    assign max_x   = {{(X_W - ANGLE_W){1'b0}}, max_angle_reg};
    assign clamp_a = (x_reg < min_x) ? min_angle_reg :
                     (x_reg > max_x) ? max_angle_reg : x_reg[ANGLE_W-1:0];

    // Duty scaling terms
    assign pulse_diff = {1'b0, max_pulse_reg} - {1'b0, min_pulse_reg};
    assign period_eff = (period_reg == '0) ? PERIOD_W'(1) : period_reg;
    assign bits_eff   = (bits_reg == '0) ? BITS_W'(1) :
                        (bits_reg > BITS_W'(DUTY_W)) ? BITS_W'(DUTY_W) : bits_reg;
    assign full       = DUTY_W'(((DUTY_W + 1)'(1) << bits_eff) - (DUTY_W + 1)'(1));

    // Multiplier, numerator and divider steps
    assign acc_add = acc_reg + (mpl_reg[0] ? mcand_reg : PROD_W'(0));
    assign num     = acc_reg + {{(PROD_W - BASE_W){1'b0}}, base_reg};
    assign num_pos = !num[PROD_W-1] && (num != '0);
    assign nfull   = ({{DUTY_W{1'b0}}, num[NPOS_W-1:0]} << bits_eff)
                     - {{DUTY_W{1'b0}}, num[NPOS_W-1:0]};
    assign sat     = ({{(D_W + DUTY_W - N_W){1'b0}}, rem_reg} >= {d_reg, {DUTY_W{1'b0}}});
    assign ge      = ({{(DSH_W - N_W){1'b0}}, rem_reg} >= dsh_reg);
    assign q_step  = {q_reg[DUTY_W-2:0], ge};
    assign q_sat   = (q_step > full) ? full : q_step;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        min_angle_next = min_angle_reg;
        max_angle_next = max_angle_reg;
        center_next    = center_reg;
        min_pulse_next = min_pulse_reg;
        max_pulse_next = max_pulse_reg;
        period_next    = period_reg;
        bits_next      = bits_reg;
        stored_next    = stored_reg;
        act_next       = act_reg;
        ch_next        = ch_reg;
        tgt_next       = tgt_reg;
        cur_next       = cur_reg;
        step_next      = step_reg;
        x_next         = x_reg;
        wr_next        = wr_reg;
        pass_next      = pass_reg;
        angle_next     = angle_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        mpl_next       = mpl_reg;
        base_next      = base_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        duty_next      = duty_reg;
        res_angle_next = res_angle_reg;
        res_duty_next  = res_duty_reg;
        res_wr_next    = res_wr_reg;
        res_ch_next    = res_ch_reg;

        // Drop the result once its beat is taken
        if (res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    act_next   = act_t'(cmd.action);
                    ch_next    = cmd.channel;
                    tgt_next   = cmd.target_angle;
                    cur_next   = cmd.current_angle;
                    step_next  = cmd.step_limit;
                    state_next = ST_MOVE;
                end
            end

            // Decode the action: new angle, write decision, pass-through angle
            ST_MOVE:
            begin
                unique case (act_reg)
                    ACT_SET:
                    begin
                        x_next    = tgt_x;
                        wr_next   = ch_valid;
                        pass_next = tgt_reg;
                    end
                    ACT_MOVE:
                    begin
                        x_next    = move_x;
                        wr_next   = ch_valid && out_band;
                        pass_next = cur_reg;
                    end
                    default:
                    begin
                        x_next    = tgt_x;
                        wr_next   = 1'b0;
                        pass_next = get_angle;
                    end
                endcase
                state_next = ST_CLAMP;
            end

            // Store the clamped angle and load the multiplier, or pass the angle on with a zero duty
            ST_CLAMP:
            begin
                if (wr_reg)
                begin
                    stored_next[ch_idx] = clamp_a;
                    angle_next = {1'b0, clamp_a};
                    acc_next   = '0;
                    mcand_next = {{(PROD_W - PULSE_W - 1){pulse_diff[PULSE_W]}}, pulse_diff};
                    mpl_next   = clamp_a;
                    base_next  = BASE_W'(min_pulse_reg) * BASE_W'(SPAN);
                    d_next     = D_W'(period_eff) * D_W'(SPAN);
                    cnt_next   = MUL_LAST;
                    state_next = ST_MUL;
                end
                else
                begin
                    angle_next = pass_reg;
                    duty_next  = '0;
                    state_next = ST_DONE;
                end
            end

            // Shift-add one angle bit per cycle
            ST_MUL:
            begin
                acc_next   = acc_add;
                mcand_next = mcand_reg <<< 1;
                mpl_next   = mpl_reg >> 1;
                cnt_next   = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_NUM;
                end
            end

            // Form the numerator and align the divisor
            ST_NUM:
            begin
                if (num_pos)
                begin
                    rem_next   = nfull;
                    dsh_next   = {d_reg, {(DUTY_W - 1){1'b0}}};
                    state_next = ST_SAT;
                end
                else
                begin
                    duty_next  = '0;
                    state_next = ST_DONE;
                end
            end

            // Saturate when the quotient would not fit the duty width
            ST_SAT:
            begin
                if (sat)
                begin
                    duty_next  = full;
                    state_next = ST_DONE;
                end
                else
                begin
                    q_next     = '0;
                    cnt_next   = DIV_LAST;
                    state_next = ST_DIV;
                end
            end

            // Restoring division, one quotient bit per cycle
            ST_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg[N_W-1:0];
                end
                q_next   = q_step;
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    duty_next  = q_sat;
                    state_next = ST_DONE;
                end
            end

            // Hand the result to the output register when it is free
            ST_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next = 1'b1;
                    res_angle_next = angle_reg;
                    res_duty_next  = duty_reg;
                    res_wr_next    = wr_reg;
                    res_ch_next    = ch_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Configuration writes
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MIN_ANGLE:    min_angle_next = cfg_data[ANGLE_W-1:0];
                CFG_MAX_ANGLE:    max_angle_next = cfg_data[ANGLE_W-1:0];
                CFG_CENTER_ANGLE: center_next    = cfg_data[ANGLE_W-1:0];
                CFG_MIN_PULSE:    min_pulse_next = cfg_data[PULSE_W-1:0];
                CFG_MAX_PULSE:    max_pulse_next = cfg_data[PULSE_W-1:0];
                CFG_PERIOD:       period_next    = cfg_data[PERIOD_W-1:0];
                CFG_DUTY_BITS:    bits_next      = cfg_data[BITS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state, configuration and stored angles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
            min_angle_reg <= MIN_ANGLE_RST;
            max_angle_reg <= MAX_ANGLE_RST;
            center_reg    <= CENTER_ANGLE_RST;
            min_pulse_reg <= MIN_PULSE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
            period_reg    <= PERIOD_RST;
            bits_reg      <= DUTY_BITS_RST;
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                stored_reg[i] <= (i == VALVE_CHANNEL) ? ANGLE_W'(VALVE_RESET_ANGLE)
                                                      : CENTER_ANGLE_RST;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
            min_angle_reg <= min_angle_next;
            max_angle_reg <= max_angle_next;
            center_reg    <= center_next;
            min_pulse_reg <= min_pulse_next;
            max_pulse_reg <= max_pulse_next;
            period_reg    <= period_next;
            bits_reg      <= bits_next;
            stored_reg    <= stored_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        ch_reg        <= ch_next;
        tgt_reg       <= tgt_next;
        cur_reg       <= cur_next;
        step_reg      <= step_next;
        x_reg         <= x_next;
        wr_reg        <= wr_next;
        pass_reg      <= pass_next;
        angle_reg     <= angle_next;
        acc_reg       <= acc_next;
        mcand_reg     <= mcand_next;
        mpl_reg       <= mpl_next;
        base_reg      <= base_next;
        d_reg         <= d_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        q_reg         <= q_next;
        duty_reg      <= duty_next;
        res_angle_reg <= res_angle_next;
        res_duty_reg  <= res_duty_next;
        res_wr_reg    <= res_wr_next;
        res_ch_reg    <= res_ch_next;
    end

    // Remainder stays below twice the aligned divisor through the division
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> ({1'b0, rem_reg} < {dsh_reg, 1'b0}))
        else $error("divider remainder out of range");

    // Multiplier hands over to the numerator step after its last bit
    a_mul_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && cnt_reg == '0) |=> (state_reg == ST_NUM))
        else $error("multiplier did not finish");

    // A duty update only ever goes to an existing channel
    a_wr_channel: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_wr_reg) |->
            ({1'b0, res_ch_reg} < (CH_W + 1)'(CHANNEL_COUNT)))
        else $error("duty written for a bad channel");

    // No update means a zero duty
    a_idle_duty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_wr_reg) |-> (res_duty_reg == '0))
        else $error("duty reported without an update");

endmodule

`default_nettype wire

// File: tb/sv/servo_slew_pwm_duty_tb.sv
module servo_slew_pwm_duty_tb;
    import ssp_pkg::*;

    localparam int CFG_COUNT       = 7;
    localparam int PHASE_COUNT     = 10;
    localparam int ITEMS_PER_PHASE = 115;
    localparam int HOLD_CYCLES     = 400;
    localparam int TAIL_CYCLES     = 60;
    localparam int QUIET_LIMIT     = 4000;
    localparam int SHOWN_ERRORS    = 10;

    // Action code 3 is unused and decodes like a get
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    typedef enum int {FLOW_OPEN, FLOW_3OF4, FLOW_COIN, FLOW_TRICKLE} flow_mode_t;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [CH_W-1:0]         channel;
        logic signed [AIO_W-1:0] target;
        logic signed [AIO_W-1:0] current;
        logic [ANGLE_W-1:0]      step_limit;
    } servo_cmd_t;

    typedef struct packed {
        logic signed [AIO_W-1:0] angle;
        logic [DUTY_W-1:0]       duty;
        logic                    written;
        logic [CH_W-1:0]         channel;
    } servo_res_t;

    typedef struct packed {
        servo_cmd_t cmd;
        logic       typed;
        servo_res_t res;
    } stim_row_t;

    typedef struct packed {
        logic [ANGLE_W-1:0]  min_angle;
        logic [ANGLE_W-1:0]  max_angle;
        logic [ANGLE_W-1:0]  center_angle;
        logic [PULSE_W-1:0]  min_pulse;
        logic [PULSE_W-1:0]  max_pulse;
        logic [PERIOD_W-1:0] period;
        logic [BITS_W-1:0]   duty_bits;
    } servo_cfg_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ssp_in_if  cmd_if ();
    ssp_out_if res_if ();

    servo_slew_pwm_duty dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_if),
        .res       (res_if)
    );

    // Shadow copy of the block state
    servo_cfg_t         shadow_cfg;
    logic [ANGLE_W-1:0] shadow_angle [CHANNEL_COUNT];

    servo_res_t pending_results [$];
    stim_row_t  stim_rows [$];
    servo_res_t head_result;

    int bad_beats     = 0;
    int quiet_cycles  = 0;
    int burst_left    = 0;
    bit no_gap        = 1'b0;
    bit long_hold_due = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Work out the result beat of one command and advance the shadow state
    function automatic servo_res_t next_servo_result(input servo_cmd_t c);
        servo_res_t  r;
        int          tgt;
        int          cur;
        int          lim;
        int          diff;
        int          mag;
        int          x;
        int unsigned bits;
        longint      full_scale;
        longint      period;
        longint      num;
        longint      q;
        bit          ch_ok;
        bit          update;

        tgt = int'(c.target);
        cur = int'(c.current);
        lim = int'(c.step_limit);
        ch_ok = (c.channel < CHANNEL_COUNT);
        update = 1'b0;
        x = 0;
        r.channel = c.channel;
        r.duty = '0;
        r.written = 1'b0;

        case (c.action)
            ACT_SET:
            begin
                r.angle = c.target;
                if (ch_ok)
                begin
                    update = 1'b1;
                    x = tgt;
                end
            end
            ACT_MOVE:
            begin
                r.angle = c.current;
                if (ch_ok)
                begin
                    diff = tgt - cur;
                    mag = (diff < 0) ? -diff : diff;
                    if (mag >= DEADBAND)
                    begin
                        update = 1'b1;
                        if (mag <= lim)
                            x = cur + diff;
                        else
                            x = (diff > 0) ? cur + lim : cur - lim;
                    end
                end
            end
            default:
            begin
                if (ch_ok)
                    r.angle = AIO_W'(shadow_angle[c.channel]);
                else
                    r.angle = AIO_W'(shadow_cfg.center_angle);
            end
        endcase

        // Clamp, store and derive the duty as one exact ratio
        if (update)
        begin
            if (x < int'(shadow_cfg.min_angle))
                x = int'(shadow_cfg.min_angle);
            else if (x > int'(shadow_cfg.max_angle))
                x = int'(shadow_cfg.max_angle);
            shadow_angle[c.channel] = x[ANGLE_W-1:0];
            r.angle = AIO_W'(x);

            bits = 32'(shadow_cfg.duty_bits);
            if (bits < 1)
                bits = 1;
            if (bits > 16)
                bits = 16;
            full_scale = (longint'(1) << bits) - 1;
            period = (shadow_cfg.period == 0) ? longint'(1) : longint'(shadow_cfg.period);
            num = longint'(shadow_cfg.min_pulse) * SPAN
                + longint'(x) * (longint'(shadow_cfg.max_pulse) - longint'(shadow_cfg.min_pulse));
            if (num <= 0)
                q = 0;
            else
            begin
                q = (num * full_scale) / (longint'(SPAN) * period);
                if (q > full_scale)
                    q = full_scale;
            end
            r.duty = DUTY_W'(q);
            r.written = 1'b1;
        end
        return r;
    endfunction

    function automatic stim_row_t stim_row(input logic [ACT_W-1:0] act, input int ch,
                                           input int tgt, input int cur, input int lim,
                                           input bit typed = 1'b0, input int e_angle = 0,
                                           input int e_duty = 0, input bit e_written = 1'b0);
        stim_row_t row;

        row.cmd.action = act;
        row.cmd.channel = CH_W'(ch);
        row.cmd.target = AIO_W'(tgt);
        row.cmd.current = AIO_W'(cur);
        row.cmd.step_limit = ANGLE_W'(lim);
        row.typed = typed;
        row.res.angle = AIO_W'(e_angle);
        row.res.duty = DUTY_W'(e_duty);
        row.res.written = e_written;
        row.res.channel = CH_W'(ch);
        return row;
    endfunction

    // Offer one command beat, opening a new burst after a random gap
    task automatic offer_cmd(input servo_cmd_t c, input bit typed, input servo_res_t typed_res);
        servo_res_t predicted;
        int         gap;
        int         roll;

        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            roll = $urandom_range(7);
            if (no_gap || roll < 3)
                gap = 0;
            else if (roll < 7)
                gap = $urandom_range(1, 4);
            else
                gap = $urandom_range(10, 50);
            if (gap > 0)
            begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        cmd_if.valid <= 1'b1;
        cmd_if.action <= c.action;
        cmd_if.channel <= c.channel;
        cmd_if.target_angle <= c.target;
        cmd_if.current_angle <= c.current;
        cmd_if.step_limit <= c.step_limit;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        predicted = next_servo_result(c);
        pending_results.push_back(typed ? typed_res : predicted);
        burst_left--;
    endtask

    // Hold the sender until every result beat is back
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_MIN_ANGLE:    shadow_cfg.min_angle = val[ANGLE_W-1:0];
            CFG_MAX_ANGLE:    shadow_cfg.max_angle = val[ANGLE_W-1:0];
            CFG_CENTER_ANGLE: shadow_cfg.center_angle = val[ANGLE_W-1:0];
            CFG_MIN_PULSE:    shadow_cfg.min_pulse = val[PULSE_W-1:0];
            CFG_MAX_PULSE:    shadow_cfg.max_pulse = val[PULSE_W-1:0];
            CFG_PERIOD:       shadow_cfg.period = val[PERIOD_W-1:0];
            CFG_DUTY_BITS:    shadow_cfg.duty_bits = val[BITS_W-1:0];
            default:          ;
        endcase
    endtask

    // Stimulus: directed table, then random phases under changing settings
    initial
    begin
        servo_cmd_t            c;
        stim_row_t             row;
        logic [CFG_DATA_W-1:0] reg_vals [CFG_COUNT];
        int                    roll;

        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_MIN_ANGLE;
        cfg_data <= '0;
        cmd_if.valid <= 1'b0;
        cmd_if.action <= ACT_GET;
        cmd_if.channel <= '0;
        cmd_if.target_angle <= '0;
        cmd_if.current_angle <= '0;
        cmd_if.step_limit <= '0;

        shadow_cfg.min_angle = MIN_ANGLE_RST;
        shadow_cfg.max_angle = MAX_ANGLE_RST;
        shadow_cfg.center_angle = CENTER_ANGLE_RST;
        shadow_cfg.min_pulse = MIN_PULSE_RST;
        shadow_cfg.max_pulse = MAX_PULSE_RST;
        shadow_cfg.period = PERIOD_RST;
        shadow_cfg.duty_bits = DUTY_BITS_RST;
        for (int i = 0; i < CHANNEL_COUNT; i++)
            shadow_angle[i] = (i == VALVE_CHANNEL) ? ANGLE_W'(VALVE_RESET_ANGLE) : CENTER_ANGLE_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state, extremes, bad channels and the deadband edges
        stim_rows.push_back(stim_row(ACT_GET, 0, -1, -1, 32767, 1, 9000, 0, 0));
        stim_rows.push_back(stim_row(ACT_GET, 2, 32767, 0, 0, 1, 0, 0, 0));
        stim_rows.push_back(stim_row(ACT_GET, 7, 0, 0, 0, 1, 9000, 0, 0));
        stim_rows.push_back(stim_row(ACT_SPARE, 1, 5, 5, 5, 1, 9000, 0, 0));
        stim_rows.push_back(stim_row(ACT_SET, 0, 0, 0, 0, 1, 0, 1638, 1));
        stim_rows.push_back(stim_row(ACT_SET, 0, 18000, 0, 0, 1, 18000, 8191, 1));
        stim_rows.push_back(stim_row(ACT_SET, 1, -32768, 0, 0, 1, 0, 1638, 1));
        stim_rows.push_back(stim_row(ACT_SET, 1, 32767, 0, 0, 1, 18000, 8191, 1));
        stim_rows.push_back(stim_row(ACT_SET, 2, 9000, 0, 0, 1, 9000, 4915, 1));
        stim_rows.push_back(stim_row(ACT_SET, 3, -32768, 0, 0, 1, -32768, 0, 0));
        stim_rows.push_back(stim_row(ACT_MOVE, 7, 100, 32767, 50, 1, 32767, 0, 0));
        stim_rows.push_back(stim_row(ACT_MOVE, 0, 1009, 1000, 500, 1, 1000, 0, 0));
        stim_rows.push_back(stim_row(ACT_MOVE, 0, 1000, 1009, 500, 1, 1009, 0, 0));
        stim_rows.push_back(stim_row(ACT_MOVE, 0, 1010, 1000, 32767));
        stim_rows.push_back(stim_row(ACT_MOVE, 0, 990, 1000, 5));
        stim_rows.push_back(stim_row(ACT_MOVE, 1, 32767, -32768, 32767));
        stim_rows.push_back(stim_row(ACT_MOVE, 1, -32768, 32767, 0));
        stim_rows.push_back(stim_row(ACT_MOVE, 2, 5000, 4000, 300));
        stim_rows.push_back(stim_row(ACT_MOVE, 2, 4000, 5000, 18000));
        stim_rows.push_back(stim_row(ACT_GET, 0, 0, 0, 0));
        stim_rows.push_back(stim_row(ACT_GET, 1, 0, 0, 0));
        stim_rows.push_back(stim_row(ACT_SPARE, 2, 0, 0, 0));
        stim_rows.push_back(stim_row(ACT_GET, 5, 0, 0, 0));

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            offer_cmd(row.cmd, row.typed, row.res);
        end

        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_results();

            // Register values in index order
            case (phase)
                0: reg_vals = '{CFG_DATA_W'(MIN_ANGLE_RST), CFG_DATA_W'(MAX_ANGLE_RST),
                                CFG_DATA_W'(CENTER_ANGLE_RST), CFG_DATA_W'(MIN_PULSE_RST),
                                CFG_DATA_W'(MAX_PULSE_RST), PERIOD_RST,
                                CFG_DATA_W'(DUTY_BITS_RST)};
                1: reg_vals = '{0, 32767, 32767, 0, 65535, 1, 16};
                2: reg_vals = '{32767, 0, 0, 65535, 0, 20'hFFFFF, 1};
                3: reg_vals = '{0, 32767, 18000, 3000, 100, 20000, 12};
                4: reg_vals = '{1000, 17000, 4500, 500, 2500, 0, 31};
                5: reg_vals = '{0, 18000, 9000, 1000, 2000, 2, 0};
                default:
                begin
                    reg_vals[CFG_MIN_ANGLE] = CFG_DATA_W'($urandom_range(SPAN));
                    reg_vals[CFG_MAX_ANGLE] = CFG_DATA_W'($urandom_range(SPAN));
                    reg_vals[CFG_CENTER_ANGLE] = CFG_DATA_W'($urandom_range(32767));
                    reg_vals[CFG_MIN_PULSE] = CFG_DATA_W'($urandom_range(1)
                                                          ? $urandom_range(400, 1500)
                                                          : $urandom_range(65535));
                    reg_vals[CFG_MAX_PULSE] = CFG_DATA_W'($urandom_range(1)
                                                          ? $urandom_range(1500, 2600)
                                                          : $urandom_range(65535));
                    roll = $urandom_range(3);
                    if (roll < 2)
                        reg_vals[CFG_PERIOD] = CFG_DATA_W'($urandom_range(1000, 40000));
                    else if (roll == 2)
                        reg_vals[CFG_PERIOD] = CFG_DATA_W'($urandom_range(5000));
                    else
                        reg_vals[CFG_PERIOD] = CFG_DATA_W'($urandom);
                    reg_vals[CFG_DUTY_BITS] = CFG_DATA_W'($urandom_range(31));
                    // Last phase: raw data, bits above each register are dropped
                    if (phase == PHASE_COUNT - 1)
                        for (int i = 0; i < CFG_COUNT; i++)
                            reg_vals[i] = CFG_DATA_W'($urandom);
                end
            endcase
            for (int i = 0; i < CFG_COUNT; i++)
                write_reg(cfg_idx_t'(i), reg_vals[i]);
            cfg_write <= 1'b0;

            // Back-to-back offers against a long receiver hold-off
            no_gap = (phase == 2 || phase == 7);
            if (no_gap)
                long_hold_due = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 30)
                    c.action = ACT_SET;
                else if (roll < 75)
                    c.action = ACT_MOVE;
                else if (roll < 95)
                    c.action = ACT_GET;
                else
                    c.action = ACT_SPARE;

                if ($urandom_range(9) < 8)
                    c.channel = CH_W'($urandom_range(CHANNEL_COUNT - 1));
                else
                    c.channel = CH_W'($urandom_range(7));

                case ($urandom_range(3))
                    0:       c.target = AIO_W'($urandom);
                    1:       c.target = AIO_W'(int'(shadow_cfg.min_angle) + $urandom_range(40) - 20);
                    default: c.target = AIO_W'($urandom_range(SPAN));
                endcase

                // Mostly continue from the stored angle, as a slewing caller would
                if (c.channel < CHANNEL_COUNT && $urandom_range(9) < 6)
                    c.current = AIO_W'(shadow_angle[c.channel]);
                else if ($urandom_range(3) == 0)
                    c.current = AIO_W'($urandom);
                else
                    c.current = AIO_W'($urandom_range(SPAN));

                // Land on both sides of the deadband now and then
                if (c.action == ACT_MOVE && $urandom_range(3) == 0)
                    c.target = c.current + AIO_W'($urandom_range(2 * DEADBAND + 4))
                             - AIO_W'(DEADBAND + 2);

                case ($urandom_range(3))
                    0:       c.step_limit = ANGLE_W'($urandom);
                    1:       c.step_limit = ANGLE_W'($urandom_range(SPAN));
                    default: c.step_limit = ANGLE_W'($urandom_range(600));
                endcase

                offer_cmd(c, 1'b0, '0);
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (bad_beats == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Result side: stall on a pattern of its own, with one-off long holds
    initial
    begin
        flow_mode_t mode;
        int         mode_left;
        int         tick;

        res_if.ready <= 1'b0;
        mode = FLOW_OPEN;
        mode_left = 0;
        tick = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_due)
            begin
                long_hold_due = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode = flow_mode_t'($urandom_range(3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            tick++;
            case (mode)
                FLOW_OPEN:    res_if.ready <= 1'b1;
                FLOW_3OF4:    res_if.ready <= (tick % 4) != 0;
                FLOW_COIN:    res_if.ready <= 1'($urandom_range(1));
                default:      res_if.ready <= (tick % 8) == 0;
            endcase
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                if (bad_beats < SHOWN_ERRORS)
                    $display("unexpected result beat: angle %0d duty %0d written %0b channel %0d",
                             res_if.angle_out, res_if.duty, res_if.duty_written,
                             res_if.channel_out);
                bad_beats++;
            end
            else
            begin
                head_result = pending_results.pop_front();
                if (res_if.angle_out !== head_result.angle || res_if.duty !== head_result.duty
                    || res_if.duty_written !== head_result.written
                    || res_if.channel_out !== head_result.channel)
                begin
                    if (bad_beats < SHOWN_ERRORS)
                    begin
                        $write("result mismatch: expected angle %0d duty %0d written %0b ",
                               head_result.angle, head_result.duty, head_result.written);
                        $display("channel %0d, got angle %0d duty %0d written %0b channel %0d",
                                 head_result.channel, res_if.angle_out, res_if.duty,
                                 res_if.duty_written, res_if.channel_out);
                    end
                    bad_beats++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
